>>> sv/tbpc_pkg.sv
// Package for the three-button panel controller: widths, reset values,
// register indexes, debounce event codes and the structs passed between modules.
// No dependencies.
package tbpc_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int SP_W       = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = CFG_W'(20);
    localparam logic [CFG_W-1:0] LONG_PRESS_RST  = CFG_W'(1000);
    localparam logic [CFG_W-1:0] COMBO_HOLD_RST  = CFG_W'(2000);
    localparam logic [SP_W-1:0]  SP_MIN_RST      = SP_W'(0);
    localparam logic [SP_W-1:0]  SP_MAX_RST      = SP_W'(1000);
    localparam logic [SP_W-1:0]  SP_STEP_RST     = SP_W'(5);
    localparam logic [SP_W-1:0]  SP_INITIAL_RST  = SP_W'(400);

    typedef logic [TIMER_BITS-1:0] timer_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 3'd0,
        CFG_LONG_PRESS = 3'd1,
        CFG_COMBO_HOLD = 3'd2,
        CFG_SP_MIN     = 3'd3,
        CFG_SP_MAX     = 3'd4,
        CFG_SP_STEP    = 3'd5,
        CFG_SP_INITIAL = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DEB_NONE    = 2'd0,
        DEB_PRESS   = 2'd1,
        DEB_RELEASE = 2'd2
    } deb_ev_t;

    typedef struct packed {
        logic    stable;
        deb_ev_t ev;
    } deb_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] combo_hold_ticks;
        logic [SP_W-1:0]  setpoint_min;
        logic [SP_W-1:0]  setpoint_max;
        logic [SP_W-1:0]  setpoint_step;
        logic [SP_W-1:0]  setpoint_initial;
    } cfg_t;

    typedef struct packed {
        logic [2:0]      stable_levels;
        logic [2:0]      button_flags;
        logic            screen_is_debug;
        logic            redraw_request;
        logic            editing;
        logic            tank_selected;
        logic [SP_W-1:0] main_setpoint;
        logic [SP_W-1:0] reserve_setpoint;
    } ctrl_res_t;

    function automatic timer_t sat_inc(input timer_t v);
        sat_inc = (v == {TIMER_BITS{1'b1}}) ? v : v + timer_t'(1);
    endfunction

    function automatic logic [CMP_W-1:0] ext_timer(input timer_t v);
        ext_timer = CMP_W'(v);
    endfunction

    function automatic logic [CMP_W-1:0] ext_cfg(input logic [CFG_W-1:0] v);
        ext_cfg = CMP_W'(v);
    endfunction

endpackage

>>> sv/tbpc_in_if.sv
// Input channel of the panel controller: one tick with three raw button levels.
// Depends on nothing.
interface tbpc_in_if;
    logic valid;
    logic ready;
    logic up_level;
    logic set_level;
    logic down_level;

    modport source (output valid, output up_level, output set_level, output down_level,
                    input ready);
    modport sink   (input valid, input up_level, input set_level, input down_level,
                    output ready);
endinterface

>>> sv/tbpc_out_if.sv
// Result channel of the panel controller: modes, flags and setpoints per tick.
// Depends on nothing.
interface tbpc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  stable_levels;
    logic [2:0]  button_flags;
    logic        screen_is_debug;
    logic        redraw_request;
    logic        editing;
    logic        tank_selected;
    logic [10:0] main_setpoint;
    logic [10:0] reserve_setpoint;

    modport source (output valid, output stable_levels, output button_flags,
                    output screen_is_debug, output redraw_request, output editing,
                    output tank_selected, output main_setpoint, output reserve_setpoint,
                    input ready);
    modport sink   (input valid, input stable_levels, input button_flags,
                    input screen_is_debug, input redraw_request, input editing,
                    input tank_selected, input main_setpoint, input reserve_setpoint,
                    output ready);
endinterface

>>> sv/tbpc_debounce.sv
// Debouncer for one button: saturating tick counter since the last raw change.
// Depends on tbpc_pkg.
module tbpc_debounce
    import tbpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             raw,
    input  logic [CFG_W-1:0] debounce_ticks,
    output deb_out_t         result
);

    logic   raw_prev_reg;
    logic   stable_reg;
    timer_t ticks_reg;
    timer_t ticks_next;
    logic   accept;

    always_comb
    begin
        ticks_next = (raw != raw_prev_reg) ? '0 : sat_inc(ticks_reg);
        accept     = (ext_timer(ticks_next) > ext_cfg(debounce_ticks)) && (raw != stable_reg);
        result.stable = accept ? raw : stable_reg;
        if (!accept)
            result.ev = DEB_NONE;
        else if (raw)
            result.ev = DEB_RELEASE;
        else
            result.ev = DEB_PRESS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg <= 1'b1;
            stable_reg   <= 1'b1;
            ticks_reg    <= '0;
        end
        else if (advance)
        begin
            raw_prev_reg <= raw;
            stable_reg   <= result.stable;
            ticks_reg    <= ticks_next;
        end
    end

endmodule

>>> sv/tbpc_ctrl.sv
// Panel logic: up+down combo for screen mode, long/short set press for edit
// mode and tank choice, clamped setpoint steps. Depends on tbpc_pkg.
module tbpc_ctrl
    import tbpc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  deb_out_t        up_btn,
    input  deb_out_t        set_btn,
    input  deb_out_t        down_btn,
    input  cfg_t            cfg,
    input  logic            load_initial,
    input  logic [SP_W-1:0] load_value,
    output ctrl_res_t       res
);

    timer_t          set_held_reg;
    timer_t          set_held_next;
    logic            long_done_reg;
    logic            long_done_next;
    timer_t          combo_ticks_reg;
    timer_t          combo_ticks_next;
    logic            combo_prev_reg;
    logic            combo_done_reg;
    logic            combo_done_next;
    logic            debug_reg;
    logic            edit_reg;
    logic            reserve_reg;
    logic [SP_W-1:0] sp_main_reg;
    logic [SP_W-1:0] sp_res_reg;

    logic                   combo;
    logic                   set_press;
    logic                   long_cleared;
    logic                   toggle_screen;
    logic                   long_fire;
    logic                   short_release;
    logic                   edit_next;
    logic                   reserve_next;
    logic                   up_step;
    logic                   dn_step;
    logic [SP_W-1:0]        sp_cur;
    logic signed [SP_W+1:0] sp_sum;
    logic signed [SP_W+1:0] sp_lo;
    logic [SP_W-1:0]        sp_stepped;

    always_comb
    begin
        combo     = !up_btn.stable && !down_btn.stable;
        set_press = (set_btn.ev == DEB_PRESS);

        set_held_next = set_press ? '0 : sat_inc(set_held_reg);
        long_cleared  = set_press ? 1'b0 : long_done_reg;

        combo_ticks_next = (combo && combo_prev_reg) ? sat_inc(combo_ticks_reg) : '0;
        toggle_screen    = combo && !combo_done_reg
                           && (ext_timer(combo_ticks_next) >= ext_cfg(cfg.combo_hold_ticks));
        combo_done_next  = combo && (combo_done_reg || toggle_screen);

        long_fire      = !set_btn.stable && !long_cleared
                         && (ext_timer(set_held_next) >= ext_cfg(cfg.long_press_ticks));
        long_done_next = long_cleared || long_fire;
        edit_next      = edit_reg ^ long_fire;
        short_release  = (set_btn.ev == DEB_RELEASE) && !long_done_next;
        reserve_next   = reserve_reg ^ short_release;

        up_step = !combo && edit_next && (up_btn.ev == DEB_PRESS) && down_btn.stable;
        dn_step = !combo && edit_next && (down_btn.ev == DEB_PRESS) && up_btn.stable;

        // Raise to min first, then lower to max: max wins when min > max.
        sp_cur = reserve_next ? sp_res_reg : sp_main_reg;
        if (dn_step)
            sp_sum = $signed({2'b00, sp_cur}) - $signed({2'b00, cfg.setpoint_step});
        else
            sp_sum = $signed({2'b00, sp_cur}) + $signed({2'b00, cfg.setpoint_step});
        sp_lo = (sp_sum < $signed({2'b00, cfg.setpoint_min}))
                ? $signed({2'b00, cfg.setpoint_min}) : sp_sum;
        sp_stepped = (sp_lo > $signed({2'b00, cfg.setpoint_max}))
                     ? cfg.setpoint_max : sp_lo[SP_W-1:0];

        res.stable_levels    = {down_btn.stable, set_btn.stable, up_btn.stable};
        res.button_flags     = {dn_step, long_fire || short_release, up_step};
        res.screen_is_debug  = debug_reg ^ toggle_screen;
        res.redraw_request   = toggle_screen;
        res.editing          = edit_next;
        res.tank_selected    = reserve_next;
        res.main_setpoint    = ((up_step || dn_step) && !reserve_next) ? sp_stepped : sp_main_reg;
        res.reserve_setpoint = ((up_step || dn_step) && reserve_next) ? sp_stepped : sp_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_held_reg    <= '0;
            long_done_reg   <= 1'b0;
            combo_ticks_reg <= '0;
            combo_prev_reg  <= 1'b0;
            combo_done_reg  <= 1'b0;
            debug_reg       <= 1'b0;
            edit_reg        <= 1'b0;
            reserve_reg     <= 1'b0;
        end
        else if (advance)
        begin
            set_held_reg    <= set_held_next;
            long_done_reg   <= long_done_next;
            combo_ticks_reg <= combo_ticks_next;
            combo_prev_reg  <= combo;
            combo_done_reg  <= combo_done_next;
            debug_reg       <= res.screen_is_debug;
            edit_reg        <= edit_next;
            reserve_reg     <= reserve_next;
        end
    end

    // Setpoints: a write of the initial value loads both tanks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_main_reg <= SP_INITIAL_RST;
            sp_res_reg  <= SP_INITIAL_RST;
        end
        else if (load_initial)
        begin
            sp_main_reg <= load_value;
            sp_res_reg  <= load_value;
        end
        else if (advance)
        begin
            sp_main_reg <= res.main_setpoint;
            sp_res_reg  <= res.reserve_setpoint;
        end
    end

    a_redraw_flips_screen: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.redraw_request |=> debug_reg != $past(debug_reg))
        else $error("redraw without screen toggle");

    a_one_step_per_tick: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !(res.button_flags[0] && res.button_flags[2]))
        else $error("up and down step in the same tick");

    a_edit_toggle_flags_set: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (edit_next != edit_reg) |-> res.button_flags[1])
        else $error("edit mode toggled without set flag");

    a_step_only_in_edit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (up_step || dn_step) |=> edit_reg)
        else $error("setpoint stepped outside edit mode");

endmodule

>>> sv/three_button_panel_controller.sv
// Top level of the three-button panel controller: configuration registers,
// input register, three debouncers, panel logic and result register.
// Depends on tbpc_pkg, tbpc_in_if, tbpc_out_if, tbpc_debounce, tbpc_ctrl.
//
//  Channel   Dir  Payload                                            Handshake
//  keys      in   up_level, set_level, down_level                    valid/ready
//  status    out  stable_levels, button_flags, screen_is_debug,      valid/ready
//                 redraw_request, editing, tank_selected,
//                 main_setpoint, reserve_setpoint
//  cfg       in   cfg_we, cfg_index, cfg_wdata                       write only
//
//  A keys transfer is captured in the input register, then passes through the
//  debounce/panel logic into the result register.
//  One tick is taken per cycle unless status stalls; the panel state updates as
//  a tick moves into the result register, so that single update sets the rate.
//  Reset (rst_n low, asynchronous) empties both registers, releases all buttons,
//  clears the counters and modes and loads the configuration defaults.
//  A stall on status holds the result register; keys keeps accepting while
//  the input register is empty or moving on.
module three_button_panel_controller
    import tbpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tbpc_in_if.sink              keys,
    tbpc_out_if.source           status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t       cfg_reg;
    logic       s0_valid_reg;
    logic [2:0] s0_levels_reg;
    logic       out_valid_reg;
    ctrl_res_t  out_reg;

    logic       advance;
    logic       load_initial;
    deb_out_t   up_btn;
    deb_out_t   set_btn;
    deb_out_t   down_btn;
    ctrl_res_t  res;

    // Advance the input register into the result register when the result
    // register is empty or its content is transferred this cycle.
    assign advance    = s0_valid_reg && (!out_valid_reg || status.ready);
    assign keys.ready = !s0_valid_reg || advance;

    // Configuration decode; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= LONG_PRESS_RST;
            cfg_reg.combo_hold_ticks <= COMBO_HOLD_RST;
            cfg_reg.setpoint_min     <= SP_MIN_RST;
            cfg_reg.setpoint_max     <= SP_MAX_RST;
            cfg_reg.setpoint_step    <= SP_STEP_RST;
            cfg_reg.setpoint_initial <= SP_INITIAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   cfg_reg.debounce_ticks   <= cfg_wdata;
                CFG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_wdata;
                CFG_COMBO_HOLD: cfg_reg.combo_hold_ticks <= cfg_wdata;
                CFG_SP_MIN:     cfg_reg.setpoint_min     <= cfg_wdata[SP_W-1:0];
                CFG_SP_MAX:     cfg_reg.setpoint_max     <= cfg_wdata[SP_W-1:0];
                CFG_SP_STEP:    cfg_reg.setpoint_step    <= cfg_wdata[SP_W-1:0];
                CFG_SP_INITIAL: cfg_reg.setpoint_initial <= cfg_wdata[SP_W-1:0];
                default:        ;
            endcase
        end
    end

    assign load_initial = cfg_we && (cfg_index == CFG_SP_INITIAL);

    // Input register: valid under reset, levels are payload only.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (keys.ready)
            s0_valid_reg <= keys.valid;
    end

    always_ff @(posedge clk)
    begin
        if (keys.valid && keys.ready)
            s0_levels_reg <= {keys.down_level, keys.set_level, keys.up_level};
    end

    tbpc_debounce u_deb_up (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .raw            (s0_levels_reg[0]),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .result         (up_btn)
    );

    tbpc_debounce u_deb_set (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .raw            (s0_levels_reg[1]),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .result         (set_btn)
    );

    tbpc_debounce u_deb_down (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .raw            (s0_levels_reg[2]),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .result         (down_btn)
    );

    tbpc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .up_btn       (up_btn),
        .set_btn      (set_btn),
        .down_btn     (down_btn),
        .cfg          (cfg_reg),
        .load_initial (load_initial),
        .load_value   (cfg_wdata[SP_W-1:0]),
        .res          (res)
    );

    // Result register: load on advance, drop valid once transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (status.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign status.valid            = out_valid_reg;
    assign status.stable_levels    = out_reg.stable_levels;
    assign status.button_flags     = out_reg.button_flags;
    assign status.screen_is_debug  = out_reg.screen_is_debug;
    assign status.redraw_request   = out_reg.redraw_request;
    assign status.editing          = out_reg.editing;
    assign status.tank_selected    = out_reg.tank_selected;
    assign status.main_setpoint    = out_reg.main_setpoint;
    assign status.reserve_setpoint = out_reg.reserve_setpoint;

    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced tick did not reach the result register");

    a_stalled_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && !advance |=> s0_valid_reg && $stable(s0_levels_reg))
        else $error("stalled tick lost from the input register");

    a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !status.ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

endmodule

>>> dv/testbench.sv
// Self-checking bench for the three-button panel controller: drives tick streams
// with bursty valid and patterned ready, predicts every status transfer and compares.
// Depends on tbpc_pkg, tbpc_in_if, tbpc_out_if and three_button_panel_controller.
module testbench;
    import tbpc_pkg::*;

    // Index with no register behind it; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(7);

    // Raw levels are active low: bit0 up, bit1 set, bit2 down.
    localparam logic [2:0] ALL_RELEASED = 3'b111;
    localparam logic [2:0] BTN_UP       = 3'b001;
    localparam logic [2:0] BTN_SET      = 3'b010;
    localparam logic [2:0] BTN_DOWN     = 3'b100;

    localparam int     RANDOM_TICKS     = 650;
    localparam longint RUN_LIMIT        = 64'd60_000_000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_ALTERNATE,
        RX_RANDOM,
        RX_STALLS
    } rx_pattern_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    tbpc_in_if  keys ();
    tbpc_out_if status ();

    three_button_panel_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (keys),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Panel predictor: own copy of the settings and of the panel state.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_debounce;
    logic [CFG_W-1:0] cfg_long_press;
    logic [CFG_W-1:0] cfg_combo_hold;
    logic [SP_W-1:0]  cfg_sp_min;
    logic [SP_W-1:0]  cfg_sp_max;
    logic [SP_W-1:0]  cfg_sp_step;
    logic [SP_W-1:0]  cfg_sp_initial;

    logic [2:0]      raw_seen;       // last raw level per button
    logic [2:0]      level_held;     // debounced level per button
    timer_t          since_change [3];
    timer_t          set_held;
    timer_t          combo_held;
    logic            long_done;
    logic            combo_prev;
    logic            combo_done;
    logic            debug_scr;
    logic            edit_on;
    logic            reserve_sel;
    logic [SP_W-1:0] setpoint [2];   // 0 main tank, 1 reserve tank

    logic [2:0] tick_backlog [$];    // ticks waiting for the driver
    ctrl_res_t  status_due [$];      // predicted status, oldest first

    int          mismatch_count;
    int          gap_left;
    int          burst_left;
    rx_pattern_t rx_pattern;
    int          pattern_left;
    int          stall_left;

    function automatic timer_t bump(input timer_t v);
        return (v == '1) ? v : v + timer_t'(1);
    endfunction

    // Step the selected tank and clamp: raise to min first, then cap at max.
    task automatic nudge_setpoint(input logic raise);
        int v;
        v = int'(setpoint[reserve_sel]) + (raise ? int'(cfg_sp_step) : -int'(cfg_sp_step));
        if (v < int'(cfg_sp_min))
            v = int'(cfg_sp_min);
        if (v > int'(cfg_sp_max))
            v = int'(cfg_sp_max);
        setpoint[reserve_sel] = SP_W'(v);
    endtask

    // Advance the panel by one tick and queue the status it must report.
    task automatic advance_panel(input logic [2:0] raw);
        deb_ev_t    ev [3];
        logic       combo;
        logic [2:0] flags;
        logic       redraw;
        ctrl_res_t  res;
        int         b;
        flags  = 3'b000;
        redraw = 1'b0;
        for (b = 0; b < 3; b++)
        begin
            if (raw[b] != raw_seen[b])
            begin
                raw_seen[b]     = raw[b];
                since_change[b] = '0;
            end
            else
                since_change[b] = bump(since_change[b]);
            ev[b] = DEB_NONE;
            if (since_change[b] > cfg_debounce && raw[b] != level_held[b])
            begin
                level_held[b] = raw[b];
                ev[b]         = raw[b] ? DEB_RELEASE : DEB_PRESS;
            end
        end
        combo = !level_held[0] && !level_held[2];

        if (ev[1] == DEB_PRESS)
        begin
            set_held  = '0;
            long_done = 1'b0;
        end
        else
            set_held = bump(set_held);

        if (combo)
        begin
            combo_held = combo_prev ? bump(combo_held) : '0;
            combo_prev = 1'b1;
            if (!combo_done && combo_held >= cfg_combo_hold)
            begin
                combo_done = 1'b1;
                debug_scr  = ~debug_scr;
                redraw     = 1'b1;
            end
        end
        else
        begin
            combo_held = '0;
            combo_prev = 1'b0;
            combo_done = 1'b0;
        end

        if (!level_held[1] && !long_done && set_held >= cfg_long_press)
        begin
            long_done = 1'b1;
            edit_on   = ~edit_on;
            flags[1]  = 1'b1;
        end
        if (ev[1] == DEB_RELEASE && !long_done)
        begin
            reserve_sel = ~reserve_sel;
            flags[1]    = 1'b1;
        end

        if (!combo && edit_on)
        begin
            if (ev[0] == DEB_PRESS && level_held[2])
            begin
                nudge_setpoint(1'b1);
                flags[0] = 1'b1;
            end
            if (ev[2] == DEB_PRESS && level_held[0])
            begin
                nudge_setpoint(1'b0);
                flags[2] = 1'b1;
            end
        end

        res.stable_levels    = level_held;
        res.button_flags     = flags;
        res.screen_is_debug  = debug_scr;
        res.redraw_request   = redraw;
        res.editing          = edit_on;
        res.tank_selected    = reserve_sel;
        res.main_setpoint    = setpoint[0];
        res.reserve_setpoint = setpoint[1];
        status_due.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Register writes and stimulus builders.
    // ------------------------------------------------------------------

    // Drive one write; it lands at the next rising edge. Mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_DEBOUNCE:   cfg_debounce   = data;
            CFG_LONG_PRESS: cfg_long_press = data;
            CFG_COMBO_HOLD: cfg_combo_hold = data;
            CFG_SP_MIN:     cfg_sp_min     = data[SP_W-1:0];
            CFG_SP_MAX:     cfg_sp_max     = data[SP_W-1:0];
            CFG_SP_STEP:    cfg_sp_step    = data[SP_W-1:0];
            CFG_SP_INITIAL:
            begin
                cfg_sp_initial = data[SP_W-1:0];
                setpoint[0]    = data[SP_W-1:0];
                setpoint[1]    = data[SP_W-1:0];
            end
            default: ;
        endcase
    endtask

    // Wait until every tick is through and every status has been taken, then
    // let the two-stage pipeline idle.
    task automatic drain_block();
        while (tick_backlog.size() != 0 || keys.valid || status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Drain, then load a full setting; setpoint_initial only when asked.
    task automatic program_panel(input int deb, input int lp, input int ch, input int lo,
                                 input int hi, input int st, input int init,
                                 input bit load_init);
        drain_block();
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_UNMAPPED, CFG_W'($urandom));
        write_reg(CFG_DEBOUNCE, CFG_W'(deb));
        write_reg(CFG_LONG_PRESS, CFG_W'(lp));
        write_reg(CFG_COMBO_HOLD, CFG_W'(ch));
        write_reg(CFG_SP_MIN, CFG_W'(lo));
        write_reg(CFG_SP_MAX, CFG_W'(hi));
        write_reg(CFG_SP_STEP, CFG_W'(st));
        if (load_init)
            write_reg(CFG_SP_INITIAL, CFG_W'(init));
        cfg_we <= 1'b0;
    endtask

    task automatic push_ticks(input logic [2:0] lv, input int n);
        repeat (n) tick_backlog.push_back(lv);
    endtask

    // Contact bounce: flicker only the bits that differ between the two levels.
    task automatic push_bounce(input logic [2:0] src_lv, input logic [2:0] dst_lv);
        repeat ($urandom_range(0, 3))
            tick_backlog.push_back(src_lv ^ (3'($urandom) & (src_lv ^ dst_lv)));
    endtask

    // Press the buttons in mask long enough to be accepted, keep them down for hold more
    // ticks, then release long enough to be accepted again (debounce settings up to 20).
    task automatic push_press(input logic [2:0] mask, input int hold);
        logic [2:0] down_lv;
        int         settle;
        down_lv = ALL_RELEASED & ~mask;
        settle  = (cfg_debounce > 20) ? 3 : int'(cfg_debounce) + 2;
        push_bounce(ALL_RELEASED, down_lv);
        push_ticks(down_lv, settle + hold);
        push_bounce(down_lv, ALL_RELEASED);
        push_ticks(ALL_RELEASED, settle + $urandom_range(0, 2));
    endtask

    // ------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL three_button_panel_controller");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tick driver: bursts of random length separated by random gaps.
    // The predictor advances on every accepted transfer.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            keys.valid <= 1'b0;
        else
        begin
            if (keys.valid && keys.ready)
                advance_panel({keys.down_level, keys.set_level, keys.up_level});
            // Hold the current tick while the block stalls.
            if (!keys.valid || keys.ready)
            begin
                if (gap_left > 0)
                begin
                    keys.valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end
                else if (tick_backlog.size() != 0)
                begin
                    {keys.down_level, keys.set_level, keys.up_level} <= tick_backlog.pop_front();
                    keys.valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        // Mostly short bursts; now and then a long run with no gap.
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                                  : $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    keys.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Status monitor: compare each transfer with the oldest prediction, and
    // move ready through a pattern that is chosen anew at random.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : status_monitor
        ctrl_res_t seen;
        ctrl_res_t want;
        string     bad;
        if (!rst_n)
            status.ready <= 1'b0;
        else
        begin
            if (status.valid && status.ready)
            begin
                seen = {status.stable_levels, status.button_flags, status.screen_is_debug,
                        status.redraw_request, status.editing, status.tank_selected,
                        status.main_setpoint, status.reserve_setpoint};
                if (status_due.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("status transfer with nothing pending: levels %b flags %b",
                                 seen.stable_levels, seen.button_flags);
                    mismatch_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    bad  = "";
                    if (seen.stable_levels !== want.stable_levels)
                        bad = {bad, " stable_levels"};
                    if (seen.button_flags !== want.button_flags)
                        bad = {bad, " button_flags"};
                    if (seen.screen_is_debug !== want.screen_is_debug)
                        bad = {bad, " screen_is_debug"};
                    if (seen.redraw_request !== want.redraw_request)
                        bad = {bad, " redraw_request"};
                    if (seen.editing !== want.editing)
                        bad = {bad, " editing"};
                    if (seen.tank_selected !== want.tank_selected)
                        bad = {bad, " tank_selected"};
                    if (seen.main_setpoint !== want.main_setpoint)
                        bad = {bad, " main_setpoint"};
                    if (seen.reserve_setpoint !== want.reserve_setpoint)
                        bad = {bad, " reserve_setpoint"};
                    if (bad != "")
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("status mismatch in%s", bad);
                            $display("  expected lv %b fl %b dbg %b rd %b ed %b tk %b main %0d res %0d",
                                     want.stable_levels, want.button_flags, want.screen_is_debug,
                                     want.redraw_request, want.editing, want.tank_selected,
                                     want.main_setpoint, want.reserve_setpoint);
                            $display("  actual   lv %b fl %b dbg %b rd %b ed %b tk %b main %0d res %0d",
                                     seen.stable_levels, seen.button_flags, seen.screen_is_debug,
                                     seen.redraw_request, seen.editing, seen.tank_selected,
                                     seen.main_setpoint, seen.reserve_setpoint);
                        end
                        mismatch_count++;
                    end
                end
            end

            if (pattern_left == 0)
            begin
                rx_pattern   <= rx_pattern_t'($urandom_range(0, 3));
                pattern_left <= $urandom_range(32, 128);
            end
            else
                pattern_left <= pattern_left - 1;

            case (rx_pattern)
                RX_OPEN:      status.ready <= 1'b1;
                RX_ALTERNATE: status.ready <= ~status.ready;
                RX_RANDOM:    status.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    // Stall in runs of random length, otherwise keep ready high.
                    if (stall_left > 0)
                    begin
                        status.ready <= 1'b0;
                        stall_left   <= stall_left - 1;
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        status.ready <= 1'b0;
                        stall_left   <= $urandom_range(1, 4);
                    end
                    else
                        status.ready <= 1'b1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed phases, random phases.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int random_total;
        int phase_goal;
        int phase_ticks;
        int before_n;
        int profile;
        int deb, lp, ch, lo, hi, st, init, swap;
        int lp_clip, ch_clip;
        int b;

        // Drive every input to a known value and load reset state into the predictor.
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        keys.valid     = 1'b0;
        keys.up_level  = 1'b1;
        keys.set_level = 1'b1;
        keys.down_level = 1'b1;
        status.ready   = 1'b0;
        mismatch_count = 0;
        gap_left       = 0;
        burst_left     = 0;
        rx_pattern     = RX_OPEN;
        pattern_left   = 0;
        stall_left     = 0;

        cfg_debounce   = DEBOUNCE_RST;
        cfg_long_press = LONG_PRESS_RST;
        cfg_combo_hold = COMBO_HOLD_RST;
        cfg_sp_min     = SP_MIN_RST;
        cfg_sp_max     = SP_MAX_RST;
        cfg_sp_step    = SP_STEP_RST;
        cfg_sp_initial = SP_INITIAL_RST;
        raw_seen       = ALL_RELEASED;
        level_held     = ALL_RELEASED;
        for (b = 0; b < 3; b++)
            since_change[b] = '0;
        set_held    = '0;
        combo_held  = '0;
        long_done   = 1'b0;
        combo_prev  = 1'b0;
        combo_done  = 1'b0;
        debug_scr   = 1'b0;
        edit_on     = 1'b0;
        reserve_sel = 1'b0;
        setpoint[0] = SP_INITIAL_RST;
        setpoint[1] = SP_INITIAL_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: a 20-tick debounce accepts none of these short presses.
        push_ticks(3'b000, 2);
        push_ticks(ALL_RELEASED, 2);

        // Zero debounce, zero long press, zero combo hold, min above max.
        drain_block();
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        program_panel(0, 0, 0, 1200, 300, 1500, 1500, 1'b1);
        push_ticks(ALL_RELEASED & ~BTN_SET, 2);              // long press fires on press tick
        push_ticks(ALL_RELEASED, 2);                         // release after long press: no tank change
        push_ticks(ALL_RELEASED & ~BTN_UP, 2);               // step in edit mode, ends at max
        push_ticks(ALL_RELEASED, 2);
        push_ticks(ALL_RELEASED & ~(BTN_UP | BTN_DOWN), 2);  // combo toggles on its first tick
        push_ticks(ALL_RELEASED, 2);

        // Debounce at the counter ceiling: no level is ever accepted.
        program_panel(65535, 0, 0, 1200, 300, 1500, 1500, 1'b0);
        push_ticks(3'b000, 2);
        push_ticks(ALL_RELEASED, 2);

        // Random phases: new setting, then mostly well-formed presses.
        random_total = 0;
        while (random_total < RANDOM_TICKS)
        begin
            profile    = $urandom_range(0, 9);
            phase_goal = $urandom_range(40, 90);
            if (profile <= 6)
            begin
                deb = $urandom_range(0, 3);
                lp  = $urandom_range(0, 12);
                ch  = $urandom_range(0, 12);
                lo  = $urandom_range(0, 1500);
                hi  = $urandom_range(0, 1500);
                // When min comes out above max, leave it so in about one case of five.
                if (lo > hi && $urandom_range(0, 4) != 0)
                begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                st   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1500)
                                                   : $urandom_range(0, 60);
                init = $urandom_range(0, 1500);
            end
            else if (profile <= 8)
            begin
                deb  = 0;
                lp   = $urandom_range(0, 1) ? 65535 : 0;
                ch   = $urandom_range(0, 1) ? 65535 : 0;
                lo   = $urandom_range(0, 1) ? 1500 : 0;
                hi   = $urandom_range(0, 1) ? 1500 : 0;
                st   = $urandom_range(0, 1) ? 1500 : 0;
                init = $urandom_range(0, 1) ? 1500 : 0;
            end
            else
            begin
                // Huge debounce: keep these phases short, nothing gets accepted.
                deb        = $urandom_range(0, 1) ? 65535 : $urandom_range(1000, 65535);
                lp         = $urandom_range(0, 65535);
                ch         = $urandom_range(0, 65535);
                lo         = $urandom_range(0, 1500);
                hi         = $urandom_range(0, 1500);
                st         = $urandom_range(0, 1500);
                init       = $urandom_range(0, 1500);
                phase_goal = 20;
            end
            program_panel(deb, lp, ch, lo, hi, st, init, $urandom_range(0, 1));

            lp_clip     = (cfg_long_press > 40) ? 40 : int'(cfg_long_press);
            ch_clip     = (cfg_combo_hold > 40) ? 40 : int'(cfg_combo_hold);
            phase_ticks = 0;
            while (phase_ticks < phase_goal)
            begin
                before_n = tick_backlog.size();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: push_press(BTN_UP, $urandom_range(0, 3));
                    4, 5, 6, 7: push_press(BTN_DOWN, $urandom_range(0, 3));
                    8, 9, 10:   push_press(BTN_SET, $urandom_range(0, lp_clip));
                    11, 12:     push_press(BTN_SET, lp_clip + $urandom_range(0, 3));
                    13, 14:     push_press(BTN_UP | BTN_DOWN, ch_clip + $urandom_range(0, 3));
                    15:         push_press(3'($urandom), $urandom_range(0, 6));
                    16:         push_ticks(ALL_RELEASED, $urandom_range(1, 4));
                    default:
                        repeat ($urandom_range(1, 6)) tick_backlog.push_back(3'($urandom));
                endcase
                phase_ticks += tick_backlog.size() - before_n;
            end
            random_total += phase_ticks;
        end

        drain_block();
        if (mismatch_count == 0)
            $display("PASS three_button_panel_controller");
        else
            $display("FAIL three_button_panel_controller");
        $finish;
    end

endmodule

>>> sim.f
sv/tbpc_pkg.sv
sv/tbpc_in_if.sv
sv/tbpc_out_if.sv
sv/tbpc_debounce.sv
sv/tbpc_ctrl.sv
sv/three_button_panel_controller.sv
dv/testbench.sv
